// ===== sv/cdrm_pkg.sv =====
package cdrm_pkg;

    localparam int CNT_W     = 64;
    localparam int NUM_CNT   = 4;
    localparam int WIN_W     = 45;
    localparam int IN_DATA_W = 320;
    localparam int OUT_DATA_W = 304;

    localparam int FPS_FRAC_BITS = 16;

    localparam logic [CNT_W-1:0] NS_PER_SEC = 64'd1000000000;
    localparam logic [CNT_W-1:0] NS_PER_MS  = 64'd1000000;
    // frames: delta * 1e9 * 2^frac ; bytes: delta * 8e9
    localparam logic [CNT_W-1:0] FPS_MULT = NS_PER_SEC << FPS_FRAC_BITS;
    localparam logic [CNT_W-1:0] BPS_MULT = NS_PER_SEC * 64'd8;

    // ms = ((ns >> 6) * ceil(2^72 / 15625)) >> 72; exact for any 58-bit ns >> 6
    localparam int               WIN_PRE_SHIFT = 6;
    localparam int               WIN_SHIFT     = 72;
    localparam logic [CNT_W-1:0] WIN_RECIP     = 64'd302231454903657294;

    typedef struct packed {
        logic             go;
        logic [CNT_W-1:0] a;
        logic [CNT_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic             go;
        logic [CNT_W-1:0] hi;
        logic [CNT_W-1:0] lo;
        logic [CNT_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

endpackage

// ===== sv/cdrm_mul.sv =====
module cdrm_mul (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cdrm_pkg::t_mul_req  i_req,
    output cdrm_pkg::t_unit_sts o_sts,
    output logic [127:0]        o_prod
);
    import cdrm_pkg::*;

    logic [CNT_W-1:0] r_a;
    logic [CNT_W-1:0] r_b;
    logic [63:0]      r_pp;
    logic [127:0]     r_acc;
    logic [2:0]       r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [31:0]  w_a_part;
    logic [31:0]  w_b_part;
    logic [63:0]  w_pp;
    logic [1:0]   w_pos;
    logic [127:0] w_pp_shift;

    // step pairs: even = 32x32 partial product, odd = accumulate it
    always_comb begin
        w_a_part = r_cnt[1] ? r_a[63:32] : r_a[31:0];
        w_b_part = r_cnt[2] ? r_b[63:32] : r_b[31:0];
        w_pp     = w_a_part * w_b_part;
        w_pos    = {1'b0, r_cnt[1]} + {1'b0, r_cnt[2]};
        case (w_pos)
            2'd0:    w_pp_shift = {64'd0, r_pp};
            2'd1:    w_pp_shift = {32'd0, r_pp, 32'd0};
            default: w_pp_shift = {r_pp, 64'd0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.go) begin
            r_a   <= i_req.a;
            r_b   <= i_req.b;
            r_acc <= '0;
        end else if (r_busy) begin
            if (!r_cnt[0]) begin
                r_pp <= w_pp;
            end else begin
                r_acc <= r_acc + w_pp_shift;
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_prod     = r_acc;

endmodule

// ===== sv/cdrm_div.sv =====
module cdrm_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cdrm_pkg::t_div_req  i_req,
    output cdrm_pkg::t_unit_sts o_sts,
    output logic [63:0]         o_quot
);
    import cdrm_pkg::*;

    logic [CNT_W-1:0] r_rem;
    logic [CNT_W-1:0] r_lo;
    logic [CNT_W-1:0] r_den;
    logic [CNT_W-1:0] r_quot;
    logic [5:0]       r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [CNT_W:0]   w_shift;
    logic             w_ge;
    logic [CNT_W:0]   w_diff;
    logic             w_sat;

    // restoring step; bit 64 of the shifted remainder stands in for the carry
    always_comb begin
        w_shift = {r_rem, r_lo[CNT_W-1]};
        w_ge    = w_shift >= {1'b0, r_den};
        w_diff  = w_shift - {1'b0, r_den};
        w_sat   = i_req.hi >= i_req.den;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_cnt <= 6'd63;
                if (w_sat) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.go) begin
            r_rem  <= i_req.hi;
            r_lo   <= i_req.lo;
            r_den  <= i_req.den;
            r_quot <= w_sat ? '1 : '0;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff[CNT_W-1:0] : w_shift[CNT_W-1:0];
            r_lo   <= {r_lo[CNT_W-2:0], 1'b0};
            r_quot <= {r_quot[CNT_W-2:0], w_ge};
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quot     = r_quot;

endmodule

// ===== sv/counter_delta_rate_meter_top.sv =====
// Counter delta rate meter.
// Input stream: one transaction per sample. s_axis_tuser = 1 restarts the
// meter (snapshot dropped, no output); s_axis_tuser = 0 is a sample of the
// timestamp and four cumulative counters. Each sample gives one output
// transaction. m_axis_tuser = 1 means the window and four rates are valid; 0
// means the meter only re-armed (first sample, time did not advance or a
// counter went backwards) and tdata is all zero.
// A valid sample runs through one 32x32 multiplier and one 128/64 restoring
// divider (one quotient bit per cycle): window length by reciprocal multiply,
// then four multiply/divide pairs. A divide whose high half is not below the
// divisor saturates to all ones without iterating. A re-arm sample goes
// straight to the finish state; a restart leaves the sequencer idle.
// s_axis_tready is high only while the sequencer is idle. The finished result
// sits in an output register, so the next sample is taken while it waits; a
// second finished result waits in the sequencer until the receiver takes the
// first. Reset drops the snapshot and clears the output valid.
module counter_delta_rate_meter_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // time_ns, enc_frames, enc_bytes, sent_frames, sent_bytes
    input  logic [cdrm_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // op
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // window_ms, enc_fps, enc_bps, send_fps, send_bps, zero pad
    output logic [cdrm_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // available
    output logic                                m_axis_tuser
);
    import cdrm_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MS   = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0]        r_state;
    logic              r_armed;
    logic [1:0]        r_sel;
    logic              r_mul_go;
    logic              r_div_go;
    logic              r_m_valid;
    logic              r_m_user;
    logic [OUT_DATA_W-1:0] r_m_data;

    logic [CNT_W-1:0]  r_last_time;
    logic [CNT_W-1:0]  r_last_cnt [NUM_CNT];
    logic [CNT_W-1:0]  r_delta    [NUM_CNT];
    logic [CNT_W-1:0]  r_elapsed;
    logic              r_avail;
    logic [WIN_W-1:0]  r_win;
    logic [CNT_W-1:0]  r_rate     [NUM_CNT];

    logic              w_accept;
    logic [CNT_W-1:0]  w_time;
    logic [CNT_W-1:0]  w_cnt  [NUM_CNT];
    logic [CNT_W:0]    w_dlt  [NUM_CNT];
    logic              w_regressed;
    logic              w_reject;
    logic              w_load;

    t_mul_req          w_mul_req;
    t_div_req          w_div_req;
    t_unit_sts         w_mul_sts;
    t_unit_sts         w_div_sts;
    logic [127:0]      w_prod;
    logic [63:0]       w_quot;

    always_comb begin
        w_accept    = s_axis_tvalid && s_axis_tready;
        w_time      = s_axis_tdata[CNT_W-1:0];
        w_regressed = 1'b0;
        for (int i = 0; i < NUM_CNT; i++) begin
            w_cnt[i]    = s_axis_tdata[CNT_W*(i+1) +: CNT_W];
            w_dlt[i]    = {1'b0, w_cnt[i]} - {1'b0, r_last_cnt[i]};
            w_regressed = w_regressed | w_dlt[i][CNT_W];
        end
        w_reject = !r_armed || (w_time <= r_last_time) || w_regressed;
        w_load   = (r_state == ST_FIN) && (!r_m_valid || m_axis_tready);
    end

    always_comb begin
        w_mul_req.go = r_mul_go;
        if (r_state == ST_MS) begin
            w_mul_req.a = r_elapsed >> WIN_PRE_SHIFT;
            w_mul_req.b = WIN_RECIP;
        end else begin
            w_mul_req.a = r_delta[r_sel];
            w_mul_req.b = r_sel[0] ? BPS_MULT : FPS_MULT;
        end

        w_div_req.go  = r_div_go;
        w_div_req.hi  = w_prod[127:64];
        w_div_req.lo  = w_prod[63:0];
        w_div_req.den = r_elapsed;
    end

    cdrm_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .o_sts   (w_mul_sts),
        .o_prod  (w_prod)
    );

    cdrm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_sts   (w_div_sts),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_armed   <= 1'b0;
            r_sel     <= '0;
            r_mul_go  <= 1'b0;
            r_div_go  <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_mul_go <= 1'b0;
            r_div_go <= 1'b0;
            if (w_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        if (s_axis_tuser) begin
                            r_armed <= 1'b0;
                        end else if (w_reject) begin
                            r_armed <= 1'b1;
                            r_state <= ST_FIN;
                        end else begin
                            r_mul_go <= 1'b1;
                            r_state  <= ST_MS;
                        end
                    end
                end
                ST_MS: begin
                    if (w_mul_sts.done) begin
                        r_sel    <= '0;
                        r_mul_go <= 1'b1;
                        r_state  <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (w_mul_sts.done) begin
                        r_div_go <= 1'b1;
                        r_state  <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (w_div_sts.done) begin
                        if (r_sel == 2'(NUM_CNT - 1)) begin
                            r_state <= ST_FIN;
                        end else begin
                            r_sel    <= r_sel + 2'd1;
                            r_mul_go <= 1'b1;
                            r_state  <= ST_MUL;
                        end
                    end
                end
                ST_FIN: begin
                    if (w_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && !s_axis_tuser) begin
            r_last_time <= w_time;
            r_elapsed   <= w_time - r_last_time;
            for (int i = 0; i < NUM_CNT; i++) begin
                r_last_cnt[i] <= w_cnt[i];
                r_delta[i]    <= w_dlt[i][CNT_W-1:0];
            end
            r_avail <= !w_reject;
            if (w_reject) begin
                r_win <= '0;
                for (int i = 0; i < NUM_CNT; i++) begin
                    r_rate[i] <= '0;
                end
            end
        end
        if (w_mul_sts.done && r_state == ST_MS) begin
            r_win <= w_prod[WIN_SHIFT +: WIN_W];
        end
        if (w_div_sts.done && r_state == ST_DIV) begin
            r_rate[r_sel] <= w_quot;
        end
        if (w_load) begin
            r_m_user <= r_avail;
            r_m_data <= {3'd0, r_rate[3], r_rate[2], r_rate[1], r_rate[0], r_win};
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_user;
    assign m_axis_tdata  = r_m_data;

    a_idle_units: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !w_mul_sts.busy && !w_div_sts.busy)
        else $error("arithmetic unit busy while sequencer idle");

    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_sts.done |-> r_state == ST_DIV)
        else $error("divider finished outside a divide step");

    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mul_sts.done && w_div_sts.done))
        else $error("multiplier and divider finished together");

    a_rearm_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("re-arm result carries nonzero data");

endmodule
